@@ rtl/ped_pkg.sv @@
`timescale 1ns / 1ps

package ped_pkg;

    localparam int NUM_BINS      = 1024;
    localparam int SAMPLE_BITS   = 24;
    localparam int MAX_CHANNELS  = 8;

    localparam int BIN_W         = $clog2(NUM_BINS);
    localparam int OUT_BIN_W     = 10;
    localparam int CH_W          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W         = 4;
    localparam int FRAME_W       = 32;
    localparam int ACC_W         = FRAME_W + BIN_W + 1;
    localparam int PEAK_W        = SAMPLE_BITS;

    localparam int NORM_W        = 32;
    localparam int SHIFT_W       = $clog2(NORM_W);
    localparam int LOG_FRAC_BITS = 20;
    localparam int EXP_W         = $clog2(SAMPLE_BITS);
    localparam int L_W           = EXP_W + LOG_FRAC_BITS;
    localparam int K_W           = 27;
    localparam int PROD_W        = L_W + K_W;
    localparam int DB_SHIFT      = 36;
    localparam int MAG_W         = 16;
    localparam int DB_W          = 17;

    localparam int S_TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((OUT_BIN_W + DB_W + 7) / 8) * 8;

    localparam logic [K_W-1:0]    DB_K_Q16   = K_W'(101008905);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (DB_SHIFT - 1));
    localparam logic [L_W-1:0]    LOG_FULL   = L_W'((SAMPLE_BITS - 1) << LOG_FRAC_BITS);

    localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(1024);

    typedef enum logic [1:0] {
        CFG_FRAME_COUNT   = 2'd0,
        CFG_CHANNEL_COUNT = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic [OUT_BIN_W-1:0] bin;
        logic                 silent;
        logic                 rest;
        logic                 last;
    } t_meta;

endpackage

@@ rtl/ped_front.sv @@
`timescale 1ns / 1ps

module ped_front
    import ped_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_accept,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [FRAME_W-1:0]     i_cfg_data,
    output logic                   o_ev_valid,
    output logic [PEAK_W-1:0]      o_ev_peak,
    output t_meta                  o_ev_meta
);

    logic [FRAME_W-1:0] r_frames, n_frames;
    logic [CH_W-1:0]    r_ch_last, n_ch_last;
    logic [CH_W-1:0]    r_ch, n_ch;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [BIN_W-1:0]   r_bin, n_bin;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [PEAK_W-1:0]  r_peak, n_peak;
    logic               r_ev_valid, n_ev_valid;
    logic [PEAK_W-1:0]  r_ev_peak;
    t_meta              r_ev_meta;

    logic [PEAK_W-1:0]  mag, peak_next;
    logic [FRAME_W:0]   done, bin_end;
    logic               short_snd, ch_end, close, last;
    logic [CNT_W-1:0]   cnt;
    logic [FRAME_W-1:0] cfg_frames;

    always_comb begin
        mag       = i_sample[SAMPLE_BITS-1] ? (~i_sample + PEAK_W'(1)) : i_sample;
        peak_next = (mag > r_peak) ? mag : r_peak;
        done      = {1'b0, r_frame} + (FRAME_W+1)'(1);
        short_snd = r_frames < FRAME_W'(NUM_BINS);
        bin_end   = short_snd ? done : (FRAME_W+1)'(r_acc >> BIN_W);
        ch_end    = (r_ch == r_ch_last);
        close     = ch_end && (done >= bin_end);
        last      = done >= {1'b0, r_frames};
        cnt        = i_cfg_data[CNT_W-1:0];
        cfg_frames = (i_cfg_data == '0) ? FRAME_W'(1) : i_cfg_data;
    end

    always_comb begin
        n_frames   = r_frames;
        n_ch_last  = r_ch_last;
        n_ch       = r_ch;
        n_frame    = r_frame;
        n_bin      = r_bin;
        n_acc      = r_acc;
        n_peak     = r_peak;
        n_ev_valid = i_en ? (i_accept && close) : r_ev_valid;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_COUNT: begin
                    n_frames = cfg_frames;
                    n_ch     = '0;
                    n_frame  = '0;
                    n_bin    = '0;
                    n_acc    = ACC_W'(cfg_frames);
                    n_peak   = '0;
                end
                CFG_CHANNEL_COUNT: begin
                    if (cnt == '0) begin
                        n_ch_last = '0;
                    end else if (cnt > CNT_W'(MAX_CHANNELS)) begin
                        n_ch_last = CH_W'(MAX_CHANNELS - 1);
                    end else begin
                        n_ch_last = CH_W'(cnt - CNT_W'(1));
                    end
                    n_ch    = '0;
                    n_frame = '0;
                    n_bin   = '0;
                    n_acc   = ACC_W'(r_frames);
                    n_peak  = '0;
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            if (!ch_end) begin
                n_ch   = r_ch + CH_W'(1);
                n_peak = peak_next;
            end else if (!close) begin
                n_ch    = '0;
                n_frame = done[FRAME_W-1:0];
                n_peak  = peak_next;
            end else if (last) begin
                n_ch    = '0;
                n_frame = '0;
                n_bin   = '0;
                n_acc   = ACC_W'(r_frames);
                n_peak  = '0;
            end else begin
                n_ch    = '0;
                n_frame = done[FRAME_W-1:0];
                n_bin   = r_bin + BIN_W'(1);
                n_acc   = r_acc + ACC_W'(r_frames);
                n_peak  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames   <= FRAME_RESET;
            r_ch_last  <= '0;
            r_ch       <= '0;
            r_frame    <= '0;
            r_bin      <= '0;
            r_acc      <= ACC_W'(FRAME_RESET);
            r_peak     <= '0;
            r_ev_valid <= 1'b0;
        end else begin
            r_frames   <= n_frames;
            r_ch_last  <= n_ch_last;
            r_ch       <= n_ch;
            r_frame    <= n_frame;
            r_bin      <= n_bin;
            r_acc      <= n_acc;
            r_peak     <= n_peak;
            r_ev_valid <= n_ev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && close) begin
            r_ev_peak        <= peak_next;
            r_ev_meta.bin    <= OUT_BIN_W'(r_bin);
            r_ev_meta.silent <= (peak_next == '0);
            r_ev_meta.rest   <= last && short_snd;
            r_ev_meta.last   <= last;
        end
    end

    assign o_ev_valid = r_ev_valid;
    assign o_ev_peak  = r_ev_peak;
    assign o_ev_meta  = r_ev_meta;

endmodule

@@ rtl/ped_log.sv @@
`timescale 1ns / 1ps

module ped_log
    import ped_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [PEAK_W-1:0] i_peak,
    input  t_meta             i_meta,
    output logic              o_valid,
    output logic [MAG_W-1:0]  o_mag,
    output t_meta             o_meta
);

    localparam int STAGES = LOG_FRAC_BITS + 1;

    logic                     r_v    [0:STAGES-1];
    logic [NORM_W-1:0]        r_m    [0:STAGES-1];
    logic [EXP_W-1:0]         r_n    [0:STAGES-1];
    logic [LOG_FRAC_BITS-1:0] r_frac [0:STAGES-1];
    t_meta                    r_meta [0:STAGES-1];
    logic                     r_pv;
    logic [PROD_W-1:0]        r_prod;
    t_meta                    r_pmeta;

    logic [PEAK_W-1:0]        p;
    logic [EXP_W-1:0]         lead;
    logic [SHIFT_W-1:0]       shamt;
    logic [NORM_W-1:0]        n_norm;
    logic [2*NORM_W-1:0]      sq     [1:STAGES-1];
    logic [NORM_W:0]          sq_hi  [1:STAGES-1];
    logic [NORM_W-1:0]        n_m    [1:STAGES-1];
    logic                     n_bit  [1:STAGES-1];
    logic [L_W-1:0]           l_val, d_val;

    always_comb begin
        p    = (i_peak == '0) ? PEAK_W'(1) : i_peak;
        lead = '0;
        for (int i = 0; i < PEAK_W; i++) begin
            if (p[i]) begin
                lead = EXP_W'(i);
            end
        end
        shamt  = SHIFT_W'(NORM_W - 1) - SHIFT_W'(lead);
        n_norm = NORM_W'(p) << shamt;
    end

    always_comb begin
        for (int k = 1; k < STAGES; k++) begin
            sq[k]    = r_m[k-1] * r_m[k-1];
            sq_hi[k] = sq[k][2*NORM_W-1:NORM_W-1];
            n_bit[k] = sq_hi[k][NORM_W];
            n_m[k]   = n_bit[k] ? sq_hi[k][NORM_W:1] : sq_hi[k][NORM_W-1:0];
        end
        l_val = {r_n[STAGES-1], r_frac[STAGES-1]};
        d_val = (LOG_FULL > l_val) ? (LOG_FULL - l_val) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_pv <= r_v[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]    <= n_norm;
            r_n[0]    <= lead;
            r_frac[0] <= '0;
            r_meta[0] <= i_meta;
            for (int k = 1; k < STAGES; k++) begin
                r_m[k]    <= n_m[k];
                r_n[k]    <= r_n[k-1];
                r_frac[k] <= {r_frac[k-1][LOG_FRAC_BITS-2:0], n_bit[k]};
                r_meta[k] <= r_meta[k-1];
            end
            r_prod  <= PROD_W'(d_val) * PROD_W'(DB_K_Q16);
            r_pmeta <= r_meta[STAGES-1];
        end
    end

    assign o_valid = r_pv;
    assign o_mag   = MAG_W'((r_prod + ROUND_HALF) >> DB_SHIFT);
    assign o_meta  = r_pmeta;

endmodule

@@ rtl/peak_envelope_dbfs.sv @@
`timescale 1ns / 1ps

// Peak envelope meter: takes one interleaved signed sample per cycle, keeps the
// absolute peak over all channels of each bin and, when a bin closes, gives
// the peak in dBFS as signed Q9.8 with silent, rest_silent and last flags.
// A frame-count or channel-count configuration write restarts the profile.
// A sample is taken in every cycle in which no configuration write is
// offered and the output register is free or being emptied; the result for
// a closing sample passes through the event register, a normalising register,
// the 20-stage squaring pipeline that forms log2 of the peak, the dB scaling
// multiplier and the output register.
module peak_envelope_dbfs
    import ped_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // sample_value[23:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // bin_index[9:0], peak_dbfs[26:10], zero
    output logic [1:0]             m_axis_tuser,   // silent[0], rest_silent[1]
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [FRAME_W-1:0]     i_cfg_data
);

    logic              en, accept, cfg_we;
    logic              ev_valid, lg_valid;
    logic [PEAK_W-1:0] ev_peak;
    t_meta             ev_meta, lg_meta;
    logic [MAG_W-1:0]  lg_mag;

    logic              r_out_valid;
    logic [OUT_BIN_W-1:0] r_bin;
    logic [DB_W-1:0]   r_db;
    logic              r_silent, r_rest, r_last;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en && !i_cfg_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_we        = i_cfg_valid;

    ped_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_accept    (accept),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ev_valid  (ev_valid),
        .o_ev_peak   (ev_peak),
        .o_ev_meta   (ev_meta)
    );

    ped_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ev_valid),
        .i_peak  (ev_peak),
        .i_meta  (ev_meta),
        .o_valid (lg_valid),
        .o_mag   (lg_mag),
        .o_meta  (lg_meta)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= lg_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bin    <= lg_meta.bin;
            r_db     <= ~{1'b0, lg_mag} + DB_W'(1);
            r_silent <= lg_meta.silent;
            r_rest   <= lg_meta.rest;
            r_last   <= lg_meta.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - OUT_BIN_W - DB_W)'(0), r_db, r_bin};
    assign m_axis_tuser  = {r_rest, r_silent};
    assign m_axis_tlast  = r_last;

endmodule
